>>> sv/euler_rotate_perspective_project_defines.svh
// ----------------------------------------------------------------------------
// euler rotate perspective project: assertion macros
// Shared concurrent assertion forms clocked on clock.
// ----------------------------------------------------------------------------
`ifndef EULER_ROTATE_PERSPECTIVE_PROJECT_DEFINES_SVH
`define EULER_ROTATE_PERSPECTIVE_PROJECT_DEFINES_SVH

// assertion that is off while reset is high
`define ERPP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// assertion that also holds across reset
`define ERPP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> sv/erpp_pkg.sv
// ----------------------------------------------------------------------------
// erpp_pkg
// Types, constants and the sine table of the vertex rotate and project block.
// ----------------------------------------------------------------------------
package erpp_pkg;

   // sine table geometry
   localparam int SINE_DEPTH = 256;
   localparam int SINE_IDX_W = $clog2(SINE_DEPTH);

   // field and datapath widths
   localparam int ANGLE_W     = 16;
   localparam int ZOOM_W      = 15;
   localparam int COORD_W     = 16;
   localparam int TRIG_W      = 16;
   localparam int TRIG_FRAC   = 14;
   localparam int ROT_W       = 19;
   localparam int PROD_W      = 35;
   localparam int SUM_W       = 36;
   localparam int CAM_W       = 17;
   localparam int FOCAL_W     = 23;
   localparam int DEPTH_RAW_W = 20;
   localparam int DEPTH_W     = 18;
   localparam int SCREEN_W    = 24;
   localparam int NUM_W       = 42;
   localparam int QUOT_W      = 26;
   localparam int DEN_W       = 26;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // divider pipeline shape
   localparam int DIV_STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES          = QUOT_W / DIV_STEPS_PER_STAGE;

   // camera distance divider
   localparam int CAM_NUM_W   = 27;
   localparam int CAM_REM_W   = 15;
   localparam int CAM_COUNT_W = 5;

   // configuration constants
   localparam logic [ANGLE_W-1:0]     ANGLE_X_RESET = 16'd5215;
   localparam logic [ANGLE_W-1:0]     QUARTER_TURN  = 16'd16384;
   localparam logic [ZOOM_W-1:0]      ZOOM_RESET    = 15'd4096;
   localparam logic [ZOOM_W-1:0]      ZOOM_MIN      = 15'd1024;
   localparam logic [ZOOM_W-1:0]      ZOOM_MAX      = 15'd16384;
   localparam logic [CAM_NUM_W-1:0]   CAM_SCALE     = 27'd100663296;
   localparam logic [CAM_W-1:0]       CAM_RESET     = 17'd24576;
   localparam logic [CAM_COUNT_W-1:0] CAM_STEPS     = 5'd27;
   localparam logic [FOCAL_W-1:0]     FOCAL_SCALE   = 23'd300;

   // datapath constants
   localparam logic signed [SUM_W-1:0]       ROUND_BIAS  = 36'sd8192;
   localparam logic signed [DEPTH_RAW_W-1:0] DEPTH_MIN_S = 20'sd410;
   localparam logic signed [DEPTH_RAW_W-1:0] DEPTH_MAX_S = 20'sd262143;
   localparam logic [DEPTH_W-1:0]            DEPTH_MIN   = 18'd410;
   localparam logic [DEPTH_W-1:0]            DEPTH_MAX   = 18'd262143;
   localparam logic [QUOT_W-1:0]             SCREEN_LIM  = 26'd8388608;
   localparam logic [SCREEN_W-1:0]           SCREEN_MAX  = 24'h7FFFFF;
   localparam logic [SCREEN_W-1:0]           SCREEN_MIN  = 24'h800000;
   localparam logic [63:0]                   PI_Q30      = 64'd3373259426;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ANGLE_X     = 2'd0,
      CSR_ANGLE_Y     = 2'd1,
      CSR_ANGLE_Z     = 2'd2,
      CSR_ZOOM_FACTOR = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic signed [COORD_W-1:0] vertex_z;
   } req_type;

   typedef struct packed {
      logic signed [SCREEN_W-1:0] screen_x;
      logic signed [SCREEN_W-1:0] screen_y;
      logic [DEPTH_W-1:0]         view_depth;
   } rsp_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_x;
      logic signed [TRIG_W-1:0] cos_x;
      logic signed [TRIG_W-1:0] sin_y;
      logic signed [TRIG_W-1:0] cos_y;
      logic signed [TRIG_W-1:0] sin_z;
      logic signed [TRIG_W-1:0] cos_z;
   } trig_type;

   typedef struct packed {
      trig_type            trig;
      logic [CAM_W-1:0]    cam;
      logic [FOCAL_W-1:0]  focal;
      logic                busy;
   } cfg_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] num_x;
      logic signed [NUM_W-1:0] num_y;
      logic [DEPTH_W-1:0]      depth;
   } proj_type;

   typedef logic signed [TRIG_W-1:0] sine_table_type [SINE_DEPTH];

   // sine of a quarter-turn offset, taylor series in Q30, result Q1.14
   function automatic logic [63:0] quarter_sine(input logic [63:0] r);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x    = (r * PI_Q30) >> 15;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 6; n++) begin
         term = (term * x2) >> 30;
         case (n)
            1:       term = term / 64'd6;
            2:       term = term / 64'd20;
            3:       term = term / 64'd42;
            4:       term = term / 64'd72;
            5:       term = term / 64'd110;
            default: term = term / 64'd156;
         endcase
         if (n % 2 == 1) sum = sum - term;
         else            sum = sum + term;
      end
      return (sum + 64'd32768) >> 16;
   endfunction

   // sine of a full 16-bit turn angle
   function automatic logic signed [TRIG_W-1:0] turn_sine(input logic [ANGLE_W-1:0] u);
      logic [63:0]              v;
      logic signed [TRIG_W-1:0] val;
      if (u[14]) v = quarter_sine(64'd16384 - 64'(u[13:0]));
      else       v = quarter_sine(64'(u[13:0]));
      val = v[TRIG_W-1:0];
      return u[15] ? -val : val;
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type t;
      int             u;
      for (int k = 0; k < SINE_DEPTH; k++) begin
         u    = (k * 65536) / SINE_DEPTH;
         t[k] = turn_sine(ANGLE_W'(u));
      end
      return t;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

   // table entry that an angle selects
   function automatic logic [SINE_IDX_W-1:0] sine_index(input logic [ANGLE_W-1:0] angle);
      logic [31:0] p;
      p = 32'(angle) * 32'(SINE_DEPTH);
      return p[ANGLE_W +: SINE_IDX_W];
   endfunction

endpackage

>>> sv/erpp_config.sv
// ----------------------------------------------------------------------------
// erpp_config
// Configuration registers, trig lookup, focal length and the bit-serial
// camera distance divider that runs after each zoom write.
// ----------------------------------------------------------------------------
module erpp_config import erpp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   logic [ANGLE_W-1:0]     angle_x_ff, angle_x_in;
   logic [ANGLE_W-1:0]     angle_y_ff, angle_y_in;
   logic [ANGLE_W-1:0]     angle_z_ff, angle_z_in;
   logic [ZOOM_W-1:0]      zoom_ff, zoom_in;
   logic                   busy_ff, busy_in;
   logic [CAM_COUNT_W-1:0] count_ff, count_in;
   logic [CAM_NUM_W-1:0]   num_ff, num_in;
   logic [CAM_REM_W-1:0]   rem_ff, rem_in;
   logic [CAM_W-1:0]       cam_ff, cam_in;
   trig_type               trig_ff, trig_in;
   logic [FOCAL_W-1:0]     focal_ff, focal_in;

   logic [ZOOM_W-1:0]      zoom_wr;
   logic [CAM_REM_W:0]     trial;
   logic                   qbit;
   logic                   wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   // zoom write clamp
   always_comb begin
      zoom_wr = csr_wdata[ZOOM_W-1:0];
      if (zoom_wr < ZOOM_MIN) zoom_wr = ZOOM_MIN;
      if (zoom_wr > ZOOM_MAX) zoom_wr = ZOOM_MAX;
   end

   // one restoring division step per cycle while busy
   always_comb begin
      trial = {rem_ff, num_ff[CAM_NUM_W-1]};
      qbit  = (trial >= {1'b0, zoom_ff});
   end

   // register update
   always_comb begin
      angle_x_in = angle_x_ff;
      angle_y_in = angle_y_ff;
      angle_z_in = angle_z_ff;
      zoom_in    = zoom_ff;
      busy_in    = busy_ff;
      count_in   = count_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      cam_in     = cam_ff;
      if (busy_ff) begin
         num_in   = {num_ff[CAM_NUM_W-2:0], qbit};
         rem_in   = qbit ? CAM_REM_W'(trial - {1'b0, zoom_ff}) : trial[CAM_REM_W-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == CAM_COUNT_W'(1)) begin
            busy_in = 1'b0;
            cam_in  = num_in[CAM_W-1:0];
         end
      end
      if (wr) begin
         unique case (csr_index_type'(csr_index))
            CSR_ANGLE_X: angle_x_in = csr_wdata;
            CSR_ANGLE_Y: angle_y_in = csr_wdata;
            CSR_ANGLE_Z: angle_z_in = csr_wdata;
            CSR_ZOOM_FACTOR: begin
               zoom_in  = zoom_wr;
               num_in   = CAM_SCALE + CAM_NUM_W'(zoom_wr >> 1);
               rem_in   = '0;
               count_in = CAM_STEPS;
               busy_in  = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // trig lookups and focal length follow the registers
   always_comb begin
      trig_in.sin_x = SINE_TABLE[sine_index(angle_x_ff)];
      trig_in.cos_x = SINE_TABLE[sine_index(angle_x_ff + QUARTER_TURN)];
      trig_in.sin_y = SINE_TABLE[sine_index(angle_y_ff)];
      trig_in.cos_y = SINE_TABLE[sine_index(angle_y_ff + QUARTER_TURN)];
      trig_in.sin_z = SINE_TABLE[sine_index(angle_z_ff)];
      trig_in.cos_z = SINE_TABLE[sine_index(angle_z_ff + QUARTER_TURN)];
      focal_in      = FOCAL_W'(zoom_ff) * FOCAL_SCALE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_x_ff <= ANGLE_X_RESET;
         angle_y_ff <= '0;
         angle_z_ff <= '0;
         zoom_ff    <= ZOOM_RESET;
         busy_ff    <= 1'b0;
         count_ff   <= '0;
         cam_ff     <= CAM_RESET;
      end else begin
         angle_x_ff <= angle_x_in;
         angle_y_ff <= angle_y_in;
         angle_z_ff <= angle_z_in;
         zoom_ff    <= zoom_in;
         busy_ff    <= busy_in;
         count_ff   <= count_in;
         cam_ff     <= cam_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      trig_ff  <= trig_in;
      focal_ff <= focal_in;
   end

   assign cfg.trig  = trig_ff;
   assign cfg.cam   = cam_ff;
   assign cfg.focal = focal_ff;
   assign cfg.busy  = busy_ff;

endmodule

>>> sv/erpp_rotate.sv
// ----------------------------------------------------------------------------
// erpp_rotate
// Eight-stage pipeline: rotation about x, y and z, camera offset with depth
// clamp, and the numerator multiply of the projection.
// ----------------------------------------------------------------------------
module erpp_rotate import erpp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_data,
   input  cfg_type  cfg,
   output logic     out_valid,
   input  logic     out_ready,
   output proj_type out_data
);

   localparam int NSTAGE = 8;

   logic [NSTAGE-1:0] valid_ff, valid_in;
   logic [NSTAGE-1:0] adv;

   logic signed [COORD_W-1:0]     vx0_ff, vy0_ff, vz0_ff, vx0_in, vy0_in, vz0_in;
   logic signed [COORD_W-1:0]     vx1_ff, vx1_in;
   logic signed [PROD_W-1:0]      m_ycx1_ff, m_zsx1_ff, m_ysx1_ff, m_zcx1_ff;
   logic signed [PROD_W-1:0]      m_ycx1_in, m_zsx1_in, m_ysx1_in, m_zcx1_in;
   logic signed [COORD_W-1:0]     vx2_ff, vx2_in;
   logic signed [ROT_W-1:0]       y1_2_ff, z1_2_ff, y1_2_in, z1_2_in;
   logic signed [ROT_W-1:0]       y1_3_ff, y1_3_in;
   logic signed [PROD_W-1:0]      m_xcy3_ff, m_zsy3_ff, m_zcy3_ff, m_xsy3_ff;
   logic signed [PROD_W-1:0]      m_xcy3_in, m_zsy3_in, m_zcy3_in, m_xsy3_in;
   logic signed [ROT_W-1:0]       y1_4_ff, x2_4_ff, z2_4_ff, y1_4_in, x2_4_in, z2_4_in;
   logic signed [PROD_W-1:0]      m_xcz5_ff, m_ysz5_ff, m_xsz5_ff, m_ycz5_ff;
   logic signed [PROD_W-1:0]      m_xcz5_in, m_ysz5_in, m_xsz5_in, m_ycz5_in;
   logic signed [DEPTH_RAW_W-1:0] draw5_ff, draw5_in;
   logic signed [ROT_W-1:0]       x3_6_ff, y3_6_ff, x3_6_in, y3_6_in;
   logic [DEPTH_W-1:0]            depth6_ff, depth6_in;
   logic signed [NUM_W-1:0]       num_x7_ff, num_y7_ff, num_x7_in, num_y7_in;
   logic [DEPTH_W-1:0]            depth7_ff, depth7_in;

   logic signed [SUM_W-1:0] sum_y1, sum_z1, sum_x2, sum_z2, sum_x3, sum_y3;

   // stall chain: a stage moves when it is empty or the next one moves
   always_comb begin
      adv[NSTAGE-1] = ~valid_ff[NSTAGE-1] | out_ready;
      for (int i = NSTAGE - 2; i >= 0; i--) begin
         adv[i] = ~valid_ff[i] | adv[i+1];
      end
   end

   assign in_ready = adv[0];

   always_comb begin
      valid_in[0] = adv[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < NSTAGE; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   // stage 0: capture item
   assign vx0_in = in_data.vertex_x;
   assign vy0_in = in_data.vertex_y;
   assign vz0_in = in_data.vertex_z;

   // stage 1: products for rotation about x
   assign vx1_in    = vx0_ff;
   assign m_ycx1_in = vy0_ff * cfg.trig.cos_x;
   assign m_zsx1_in = vz0_ff * cfg.trig.sin_x;
   assign m_ysx1_in = vy0_ff * cfg.trig.sin_x;
   assign m_zcx1_in = vz0_ff * cfg.trig.cos_x;

   // stage 2: round back to Q.12
   assign sum_y1  = m_ycx1_ff - m_zsx1_ff + ROUND_BIAS;
   assign sum_z1  = m_ysx1_ff + m_zcx1_ff + ROUND_BIAS;
   assign vx2_in  = vx1_ff;
   assign y1_2_in = sum_y1[TRIG_FRAC +: ROT_W];
   assign z1_2_in = sum_z1[TRIG_FRAC +: ROT_W];

   // stage 3: products for rotation about y
   assign y1_3_in   = y1_2_ff;
   assign m_xcy3_in = vx2_ff * cfg.trig.cos_y;
   assign m_zsy3_in = z1_2_ff * cfg.trig.sin_y;
   assign m_zcy3_in = z1_2_ff * cfg.trig.cos_y;
   assign m_xsy3_in = vx2_ff * cfg.trig.sin_y;

   // stage 4: round
   assign sum_x2  = m_xcy3_ff + m_zsy3_ff + ROUND_BIAS;
   assign sum_z2  = m_zcy3_ff - m_xsy3_ff + ROUND_BIAS;
   assign y1_4_in = y1_3_ff;
   assign x2_4_in = sum_x2[TRIG_FRAC +: ROT_W];
   assign z2_4_in = sum_z2[TRIG_FRAC +: ROT_W];

   // stage 5: products for rotation about z, camera offset
   assign m_xcz5_in = x2_4_ff * cfg.trig.cos_z;
   assign m_ysz5_in = y1_4_ff * cfg.trig.sin_z;
   assign m_xsz5_in = x2_4_ff * cfg.trig.sin_z;
   assign m_ycz5_in = y1_4_ff * cfg.trig.cos_z;
   assign draw5_in  = {z2_4_ff[ROT_W-1], z2_4_ff} + {3'b000, cfg.cam};

   // stage 6: round and clamp depth
   assign sum_x3  = m_xcz5_ff - m_ysz5_ff + ROUND_BIAS;
   assign sum_y3  = m_xsz5_ff + m_ycz5_ff + ROUND_BIAS;
   assign x3_6_in = sum_x3[TRIG_FRAC +: ROT_W];
   assign y3_6_in = sum_y3[TRIG_FRAC +: ROT_W];

   always_comb begin
      if (draw5_ff < DEPTH_MIN_S)      depth6_in = DEPTH_MIN;
      else if (draw5_ff > DEPTH_MAX_S) depth6_in = DEPTH_MAX;
      else                             depth6_in = draw5_ff[DEPTH_W-1:0];
   end

   // stage 7: scale by focal length
   assign num_x7_in = x3_6_ff * $signed({1'b0, cfg.focal});
   assign num_y7_in = y3_6_ff * $signed({1'b0, cfg.focal});
   assign depth7_in = depth6_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         vx0_ff <= vx0_in;
         vy0_ff <= vy0_in;
         vz0_ff <= vz0_in;
      end
      if (adv[1]) begin
         vx1_ff    <= vx1_in;
         m_ycx1_ff <= m_ycx1_in;
         m_zsx1_ff <= m_zsx1_in;
         m_ysx1_ff <= m_ysx1_in;
         m_zcx1_ff <= m_zcx1_in;
      end
      if (adv[2]) begin
         vx2_ff  <= vx2_in;
         y1_2_ff <= y1_2_in;
         z1_2_ff <= z1_2_in;
      end
      if (adv[3]) begin
         y1_3_ff   <= y1_3_in;
         m_xcy3_ff <= m_xcy3_in;
         m_zsy3_ff <= m_zsy3_in;
         m_zcy3_ff <= m_zcy3_in;
         m_xsy3_ff <= m_xsy3_in;
      end
      if (adv[4]) begin
         y1_4_ff <= y1_4_in;
         x2_4_ff <= x2_4_in;
         z2_4_ff <= z2_4_in;
      end
      if (adv[5]) begin
         m_xcz5_ff <= m_xcz5_in;
         m_ysz5_ff <= m_ysz5_in;
         m_xsz5_ff <= m_xsz5_in;
         m_ycz5_ff <= m_ycz5_in;
         draw5_ff  <= draw5_in;
      end
      if (adv[6]) begin
         x3_6_ff   <= x3_6_in;
         y3_6_ff   <= y3_6_in;
         depth6_ff <= depth6_in;
      end
      if (adv[7]) begin
         num_x7_ff <= num_x7_in;
         num_y7_ff <= num_y7_in;
         depth7_ff <= depth7_in;
      end
   end

   assign out_valid      = valid_ff[NSTAGE-1];
   assign out_data.num_x = num_x7_ff;
   assign out_data.num_y = num_y7_ff;
   assign out_data.depth = depth7_ff;

endmodule

>>> sv/erpp_divide.sv
// ----------------------------------------------------------------------------
// erpp_divide
// Pipelined restoring divider for both screen axes: a setup stage that adds
// half the divisor for rounding, two quotient bits per stage, then sign and
// saturation into the output register.
// ----------------------------------------------------------------------------
module erpp_divide import erpp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  proj_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_data
);

   localparam int NSTAGE = DIV_STAGES + 2;

   logic [NSTAGE-1:0] valid_ff, valid_in;
   logic [NSTAGE-1:0] adv;

   logic [1:0][DEN_W-1:0]  rem_ff [0:DIV_STAGES];
   logic [1:0][QUOT_W-1:0] nq_ff  [0:DIV_STAGES];
   logic [1:0]             neg_ff [0:DIV_STAGES];
   logic [DEN_W-1:0]       den_ff [0:DIV_STAGES];
   logic [DEPTH_W-1:0]     dep_ff [0:DIV_STAGES];

   logic [1:0][DEN_W-1:0]  rem0_in;
   logic [1:0][QUOT_W-1:0] nq0_in;
   logic [1:0]             neg0_in;
   logic [DEN_W-1:0]       den0_in;

   rsp_type rsp_ff, rsp_in;

   // stall chain
   always_comb begin
      adv[NSTAGE-1] = ~valid_ff[NSTAGE-1] | out_ready;
      for (int i = NSTAGE - 2; i >= 0; i--) begin
         adv[i] = ~valid_ff[i] | adv[i+1];
      end
   end

   assign in_ready = adv[0];

   always_comb begin
      valid_in[0] = adv[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < NSTAGE; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   // setup: magnitude plus half divisor, leading bits into the remainder
   always_comb begin
      logic signed [NUM_W-1:0] num;
      logic [NUM_W-1:0]        mag;
      logic [NUM_W-1:0]        n;
      den0_in = {in_data.depth, 8'b0};
      for (int l = 0; l < 2; l++) begin
         num        = (l == 0) ? in_data.num_x : in_data.num_y;
         neg0_in[l] = num[NUM_W-1];
         mag        = neg0_in[l] ? NUM_W'(-num) : NUM_W'(num);
         n          = mag + NUM_W'({in_data.depth, 7'b0});
         rem0_in[l] = DEN_W'(n[NUM_W-1:QUOT_W]);
         nq0_in[l]  = n[QUOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         rem_ff[0] <= rem0_in;
         nq_ff[0]  <= nq0_in;
         neg_ff[0] <= neg0_in;
         den_ff[0] <= den0_in;
         dep_ff[0] <= in_data.depth;
      end
   end

   // quotient stages
   for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_step
      logic [1:0][DEN_W-1:0]  rem_in;
      logic [1:0][QUOT_W-1:0] nq_in;

      always_comb begin
         logic [DEN_W-1:0]  r;
         logic [QUOT_W-1:0] q;
         logic [DEN_W:0]    t;
         logic              b;
         for (int l = 0; l < 2; l++) begin
            r = rem_ff[g-1][l];
            q = nq_ff[g-1][l];
            for (int s = 0; s < DIV_STEPS_PER_STAGE; s++) begin
               t = {r, q[QUOT_W-1]};
               b = (t >= {1'b0, den_ff[g-1]});
               r = b ? DEN_W'(t - {1'b0, den_ff[g-1]}) : t[DEN_W-1:0];
               q = {q[QUOT_W-2:0], b};
            end
            rem_in[l] = r;
            nq_in[l]  = q;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[g]) begin
            rem_ff[g] <= rem_in;
            nq_ff[g]  <= nq_in;
            neg_ff[g] <= neg_ff[g-1];
            den_ff[g] <= den_ff[g-1];
            dep_ff[g] <= dep_ff[g-1];
         end
      end
   end

   // apply sign and saturate
   always_comb begin
      logic [QUOT_W-1:0]   q;
      logic [SCREEN_W-1:0] s;
      rsp_in.screen_x   = '0;
      rsp_in.screen_y   = '0;
      rsp_in.view_depth = dep_ff[DIV_STAGES];
      for (int l = 0; l < 2; l++) begin
         q = nq_ff[DIV_STAGES][l];
         if (neg_ff[DIV_STAGES][l]) s = (q >= SCREEN_LIM) ? SCREEN_MIN : -q[SCREEN_W-1:0];
         else                       s = (q >= SCREEN_LIM) ? SCREEN_MAX : q[SCREEN_W-1:0];
         if (l == 0) rsp_in.screen_x = s;
         else        rsp_in.screen_y = s;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NSTAGE-1]) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   assign out_valid = valid_ff[NSTAGE-1];
   assign out_data  = rsp_ff;

endmodule

>>> sv/euler_rotate_perspective_project.sv
// ----------------------------------------------------------------------------
// euler_rotate_perspective_project
// Rotates one Q4.12 vertex per item about x, y and z, then projects it.
//
// Channels: req_ takes a vertex, rsp_ returns screen x, screen y (Q20.4,
// saturating) and view depth (Q6.12); both use valid/ready. csr_ writes the
// angle and zoom registers by index and is always ready.
// An accepted item passes through the eight rotate stages and the fifteen
// divider stages before its result can be taken.
// Throughput: one item per cycle outside a zoom update; each stage holds
// its item while the next one is full, so a stalled receiver backs the
// pipeline up and empty stages still fill behind the held result.
// A zoom write runs a bit-serial camera distance divide; req_ready is
// low while it runs.
// Reset: angles 5215, 0, 0 and zoom 1.0, pipeline empty, and the camera
// distance preset, so items are accepted from the first cycle after reset.
// ----------------------------------------------------------------------------
module euler_rotate_perspective_project import erpp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type  cfg;
   logic     rot_ready;
   logic     rot_valid;
   logic     div_ready;
   proj_type proj;

   // registers and derived constants
   erpp_config u_config (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // hold off items while the camera distance is recomputed
   assign req_ready = rot_ready & ~cfg.busy;

   erpp_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid & ~cfg.busy),
      .in_ready  (rot_ready),
      .in_data   (req_data),
      .cfg       (cfg),
      .out_valid (rot_valid),
      .out_ready (div_ready),
      .out_data  (proj)
   );

   erpp_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_ready  (div_ready),
      .in_data   (proj),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

>>> sv/erpp_checker.sv
// ----------------------------------------------------------------------------
// erpp_checker
// Port-level assertions for the rotate and project block, bound to the top.
// ----------------------------------------------------------------------------
`include "euler_rotate_perspective_project_defines.svh"

module erpp_checker import erpp_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rsp_type                rsp_data,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index
);

   // pipeline is empty after reset
   `ERPP_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result after reset")

   // depth never falls below its clamp floor
   `ERPP_ASSERT(a_depth_floor, rsp_valid |-> rsp_data.view_depth >= DEPTH_MIN, "depth below floor")

   // a stalled result holds
   `ERPP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp moved")

   // zoom write blocks items while the camera distance updates
   `ERPP_ASSERT(a_zoom_busy, csr_valid && csr_ready && csr_index == CSR_ZOOM_FACTOR |=> !req_ready, "item taken during zoom update")

endmodule

bind euler_rotate_perspective_project erpp_checker u_checker (.*);
